### rtl/dspr_pkg.sv
// shared types and constants for the debug serial packet receiver
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package dspr_pkg;

    // largest payload a packet may announce
    localparam logic [15:0] PAYLOAD_CAPACITY = 16'd4080;
    // byte expected after the payload
    localparam logic [7:0]  TRAILER_BYTE     = 8'hAA;

    // leader register reset values
    localparam logic [31:0] DATA_LEADER_RST    = 32'h3030_3030;
    localparam logic [31:0] CONTROL_LEADER_RST = 32'h6969_6969;

    // default depth of the result queue between parser and output stage
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam logic CFG_DATA_LEADER    = 1'b0;
    localparam logic CFG_CONTROL_LEADER = 1'b1;

    // input event kinds
    typedef enum logic {
        EV_BYTE    = 1'b0,
        EV_TIMEOUT = 1'b1
    } event_kind_t;

    // result kinds
    typedef enum logic [1:0] {
        RK_PAYLOAD = 2'd0,
        RK_ACCEPT  = 2'd1,
        RK_DISCARD = 2'd2,
        RK_TIMEOUT = 2'd3
    } result_kind_t;

    // one result record
    typedef struct packed {
        result_kind_t result_kind;
        logic [7:0]   payload_data;
        logic [15:0]  packet_type;
        logic [15:0]  byte_count;
        logic [31:0]  packet_id;
        logic [31:0]  checksum_field;
        logic         is_control;
        logic         last;
    } result_t;

    // queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/dspr_parser.sv
// front end: leader search, header capture and payload/trailer classification
// depends on dspr_pkg
`timescale 1ns / 1ps

module dspr_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_wdata,
    input  logic                   in_accept,
    input  dspr_pkg::event_kind_t  in_kind,
    input  logic [7:0]             in_byte,
    output logic                   res_push,
    output dspr_pkg::result_t      res_data
);

    typedef enum logic [2:0] {
        PH_LEADER  = 3'd0,
        PH_TYPE    = 3'd1,
        PH_COUNT   = 3'd2,
        PH_ID      = 3'd3,
        PH_CSUM    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_TRAILER = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] csum_reg, csum_next;
    logic        ctrl_reg, ctrl_next;
    logic [15:0] remain_reg, remain_next;
    logic [31:0] data_leader_reg, control_leader_reg;

    // header fields as they stand after this transfer
    function automatic dspr_pkg::result_t with_header(
        input dspr_pkg::result_kind_t kind,
        input logic [7:0]  data,
        input logic [15:0] ptype,
        input logic [15:0] pcount,
        input logic [31:0] pid,
        input logic [31:0] pcsum,
        input logic        pctrl,
        input logic        fin
    );
        dspr_pkg::result_t r;
        r.result_kind    = kind;
        r.payload_data   = data;
        r.packet_type    = ptype;
        r.byte_count     = pcount;
        r.packet_id      = pid;
        r.checksum_field = pcsum;
        r.is_control     = pctrl;
        r.last           = fin;
        return r;
    endfunction

    // next state and result classification
    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        shift_next  = shift_reg;
        type_next   = type_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        csum_next   = csum_reg;
        ctrl_next   = ctrl_reg;
        remain_next = remain_reg;
        res_push    = 1'b0;
        res_data    = '0;

        if (in_accept) begin
            if (in_kind == dspr_pkg::EV_TIMEOUT) begin
                // abort from any phase, realign groups
                res_push             = 1'b1;
                res_data.result_kind = dspr_pkg::RK_TIMEOUT;
                res_data.last        = 1'b1;
                phase_next           = PH_LEADER;
                idx_next             = 2'd0;
            end else begin
                unique case (phase_reg)
                    PH_TYPE: begin
                        type_next = {in_byte, type_reg[15:8]};
                        if (idx_reg >= 2'd1) begin
                            phase_next = PH_COUNT;
                            idx_next   = 2'd0;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_COUNT: begin
                        count_next = {in_byte, count_reg[15:8]};
                        if (idx_reg >= 2'd1) begin
                            phase_next = PH_ID;
                            idx_next   = 2'd0;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_ID: begin
                        id_next = {in_byte, id_reg[31:8]};
                        if (idx_reg == 2'd3) begin
                            phase_next = PH_CSUM;
                            idx_next   = 2'd0;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_CSUM: begin
                        csum_next = {in_byte, csum_reg[31:8]};
                        if (idx_reg != 2'd3) begin
                            idx_next = idx_reg + 2'd1;
                        end else begin
                            idx_next = 2'd0;
                            if (count_reg > dspr_pkg::PAYLOAD_CAPACITY) begin
                                // oversized, drop silently
                                phase_next = PH_LEADER;
                            end else if (count_reg == 16'd0) begin
                                // empty packet completes here
                                res_push   = 1'b1;
                                res_data   = with_header(dspr_pkg::RK_ACCEPT, 8'd0, type_reg,
                                                         count_reg, id_reg, csum_next,
                                                         ctrl_reg, 1'b1);
                                phase_next = PH_LEADER;
                            end else begin
                                remain_next = count_reg;
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        res_push = 1'b1;
                        res_data = with_header(dspr_pkg::RK_PAYLOAD, in_byte, type_reg,
                                               count_reg, id_reg, csum_reg, ctrl_reg, 1'b0);
                        if (remain_reg <= 16'd1) begin
                            remain_next = 16'd0;
                            phase_next  = PH_TRAILER;
                        end else begin
                            remain_next = remain_reg - 16'd1;
                        end
                    end
                    PH_TRAILER: begin
                        res_push   = 1'b1;
                        res_data   = with_header((in_byte == dspr_pkg::TRAILER_BYTE) ?
                                                 dspr_pkg::RK_ACCEPT : dspr_pkg::RK_DISCARD,
                                                 8'd0, type_reg, count_reg, id_reg,
                                                 csum_reg, ctrl_reg, 1'b1);
                        phase_next = PH_LEADER;
                        idx_next   = 2'd0;
                    end
                    default: begin
                        // leader search; unused codes land here too
                        phase_next = PH_LEADER;
                        shift_next = {in_byte, shift_reg[31:8]};
                        if (idx_reg != 2'd3) begin
                            idx_next = idx_reg + 2'd1;
                        end else begin
                            idx_next = 2'd0;
                            if (shift_next == data_leader_reg) begin
                                ctrl_next  = 1'b0;
                                phase_next = PH_TYPE;
                            end else if (shift_next == control_leader_reg) begin
                                ctrl_next  = 1'b1;
                                phase_next = PH_TYPE;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // state and leader registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_LEADER;
            idx_reg            <= 2'd0;
            shift_reg          <= '0;
            type_reg           <= '0;
            count_reg          <= '0;
            id_reg             <= '0;
            csum_reg           <= '0;
            ctrl_reg           <= 1'b0;
            remain_reg         <= '0;
            data_leader_reg    <= dspr_pkg::DATA_LEADER_RST;
            control_leader_reg <= dspr_pkg::CONTROL_LEADER_RST;
        end else begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            shift_reg  <= shift_next;
            type_reg   <= type_next;
            count_reg  <= count_next;
            id_reg     <= id_next;
            csum_reg   <= csum_next;
            ctrl_reg   <= ctrl_next;
            remain_reg <= remain_next;
            if (cfg_we && cfg_index == dspr_pkg::CFG_DATA_LEADER) begin
                data_leader_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == dspr_pkg::CFG_CONTROL_LEADER) begin
                control_leader_reg <= cfg_wdata;
            end
        end
    end

endmodule

### rtl/dspr_queue.sv
// short result queue between the parser and the output stage
// depends on dspr_pkg
`timescale 1ns / 1ps

module dspr_queue #(
    parameter int unsigned DEPTH = dspr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  dspr_pkg::result_t        push_data,
    input  logic                     pop,
    output dspr_pkg::result_t        head_data,
    output dspr_pkg::queue_status_t  status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dspr_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_data    = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/dspr_out.sv
// back end: output register driving the result stream
// depends on dspr_pkg
`timescale 1ns / 1ps

module dspr_out (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dspr_pkg::queue_status_t  q_status,
    input  dspr_pkg::result_t        head_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output dspr_pkg::result_t        out_data
);

    logic              valid_reg, valid_next;
    dspr_pkg::result_t data_reg;

    // refill when the register is empty or its transfer completes
    assign pop = !q_status.empty && (!valid_reg || out_ready);

    always_comb begin
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= head_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/debug_serial_packet_receiver.sv
// top level of the debug serial packet receiver: parser, result queue, output stage
// depends on dspr_pkg, dspr_parser, dspr_queue, dspr_out
`timescale 1ns / 1ps

// Usage
//   s_ channel: one transfer per received serial byte (s_tuser = 0, byte in s_tdata)
//   or per link receive timeout (s_tuser = 1). The parser searches aligned
//   4-byte groups for the data or control leader, captures type, count, id
//   and checksum, then forwards each payload byte and finally reports the
//   trailer outcome; a timeout reports an abort from any phase.
//   m_ channel: zero or one result per input transfer, in order; tlast marks
//   the result that ends a packet attempt.
//   cfg port: cfg_we writes cfg_wdata to the leader selected by cfg_index
//   (0 data leader, 1 control leader); write only while the block is idle.
//   Throughput: one input transfer per cycle while the result queue is not full.
//   Path: a result enters the queue at its input transfer, then moves into the
//   output register when that register is empty or transferring, and from there
//   it transfers on m_.
//   Stall: results collect in a QUEUE_DEPTH-entry queue plus the output
//   register; s_tready drops only while the queue is full.
//   Reset: aresetn low returns the block to leader search with the leaders at
//   their reset values and both channels empty.

module debug_serial_packet_receiver #(
    parameter int unsigned QUEUE_DEPTH = dspr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    // configuration write port
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_wdata,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] rx_byte
    input  logic          s_tuser,   // [0] kind
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // [7:0] payload_data, [23:8] packet_type,
                                     // [39:24] byte_count, [71:40] packet_id,
                                     // [103:72] checksum_field
    output logic [2:0]    m_tuser,   // [1:0] result_kind, [2] is_control
    output logic          m_tlast
);

    logic                    s_xfer;
    logic                    res_push;
    dspr_pkg::result_t       res_data;
    dspr_pkg::result_t       head_data;
    dspr_pkg::result_t       out_data;
    dspr_pkg::queue_status_t q_status;
    logic                    q_pop;
    dspr_pkg::event_kind_t   in_kind;

    assign s_tready = !q_status.full;
    assign s_xfer   = s_tvalid && s_tready;
    assign in_kind  = dspr_pkg::event_kind_t'(s_tuser);

    // front end
    dspr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_accept (s_xfer),
        .in_kind   (in_kind),
        .in_byte   (s_tdata),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // decoupling queue
    dspr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .pop       (q_pop),
        .head_data (head_data),
        .status    (q_status)
    );

    // back end
    dspr_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_data (head_data),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // result packing
    assign m_tdata = {out_data.checksum_field, out_data.packet_id, out_data.byte_count,
                      out_data.packet_type, out_data.payload_data};
    assign m_tuser = {out_data.is_control, out_data.result_kind};
    assign m_tlast = out_data.last;

    // a full queue must hold off the input side
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !s_tready)
        else $error("input accepted while result queue full");

    // every timeout transfer queues an abort result
    a_timeout_aborts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser) |->
            (res_push && res_data.result_kind == dspr_pkg::RK_TIMEOUT && res_data.last))
        else $error("timeout transfer did not produce an abort result");

    // only payload results leave tlast low
    a_last_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (res_data.last == (res_data.result_kind != dspr_pkg::RK_PAYLOAD)))
        else $error("tlast inconsistent with result kind");

    // results are only produced by accepted input transfers
    a_push_needs_input: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> s_xfer)
        else $error("result queued without an input transfer");

endmodule
